@@ rtl/core/base64_decoder_unit_defines.svh @@
// Assertion macros shared by the base64 decoder RTL.
// Included by the top level; depends on nothing else.
`ifndef BASE64_DECODER_UNIT_DEFINES_SVH
`define BASE64_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/b64d_pkg.sv @@
// Package for the base64 decoder: result record, queue sizing and the
// alphabet lookup function. No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int FifoDepth = 8;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int MaxRes    = 3;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSlash  = 8'h2f;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       has_byte;
    logic       run_last;
    logic       string_end;
  } result_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    begin
      s.ok  = 1'b1;
      s.val = 6'd0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
        s.val = 6'(c - CharUpperA);
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
        s.val = 6'(c - CharLowerA + 8'd26);
      end else if (c >= CharZero && c <= CharNine) begin
        s.val = 6'(c - CharZero + 8'd52);
      end else if (c == CharPlus) begin
        s.val = 6'd62;
      end else if (c == CharSlash) begin
        s.val = 6'd63;
      end else begin
        s.ok = 1'b0;
      end
      return s;
    end
  endfunction

endpackage

@@ rtl/core/base64_decoder_unit.sv @@
// Streaming base64 decoder, one character per transaction in, one result per
// transaction out. Depends on b64d_pkg and base64_decoder_unit_defines.svh.
//
//   channel | direction | tdata                  | tuser    | tlast
//   in_     | input     | [7:0] char_in          | -        | string_last
//   out_    | output    | [7:0] byte_out,[8] run | has_byte | string_end
//
// An input character is decoded in the cycle it is accepted; its zero to
// three results are written into an eight-entry result queue at once.
// Results leave the queue one per cycle, so one character per cycle is
// sustained while the output side keeps up.
// in_tready is high while the queue has room for three results; it does not
// depend on out_tready in the same cycle.
// Reset (rst_n low, synchronous) empties the queue and clears decoder state.
`timescale 1ns / 1ps
`include "base64_decoder_unit_defines.svh"

module base64_decoder_unit
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // string_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_out, [8] run_last, rest zero
  output logic        out_tuser,  // has_byte
  output logic        out_tlast   // string_end
);

  logic [17:0]   hold_r, hold_nxt;
  logic [1:0]    scnt_r, scnt_nxt;
  logic          stopped_r, stopped_nxt;

  result_t       fifo_mem [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] fifo_cnt_r;

  logic          in_acc, out_acc;
  sextet_t       sx;
  logic [17:0]   hold_post;
  logic [1:0]    scnt_post;
  logic [7:0]    bytes [MaxRes];
  logic [1:0]    nb;
  logic [1:0]    n_res;
  result_t       res [MaxRes];

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (fifo_cnt_r <= CntW'(FifoDepth - MaxRes));

  always_comb begin
    sx          = sextet_of(in_tdata);
    hold_post   = hold_r;
    scnt_post   = scnt_r;
    stopped_nxt = stopped_r;
    nb          = 2'd0;
    for (int k = 0; k < MaxRes; k++) begin
      bytes[k] = 8'h00;
    end
    if (!stopped_r) begin
      if (sx.ok) begin
        if (scnt_r == 2'd3) begin
          bytes[0]  = hold_r[17:10];
          bytes[1]  = {hold_r[9:2]};
          bytes[2]  = {hold_r[1:0], sx.val};
          nb        = 2'd3;
          hold_post = 18'd0;
          scnt_post = 2'd0;
        end else begin
          hold_post = {hold_r[11:0], sx.val};
          scnt_post = scnt_r + 2'd1;
        end
      end else begin
        stopped_nxt = 1'b1;
      end
      if (stopped_nxt || in_tlast) begin
        if (scnt_post == 2'd2) begin
          bytes[0] = hold_post[11:4];
          nb       = 2'd1;
        end else if (scnt_post == 2'd3) begin
          bytes[0] = hold_post[17:10];
          bytes[1] = hold_post[9:2];
          nb       = 2'd2;
        end
        hold_post = 18'd0;
        scnt_post = 2'd0;
      end
    end
    if (in_tlast) begin
      hold_nxt    = 18'd0;
      scnt_nxt    = 2'd0;
      stopped_nxt = 1'b0;
    end else begin
      hold_nxt = hold_post;
      scnt_nxt = scnt_post;
    end
    n_res = (nb != 2'd0) ? nb : {1'b0, in_tlast};
    for (int k = 0; k < MaxRes; k++) begin
      if (nb == 2'd0) begin
        res[k].byte_out   = 8'h00;
        res[k].has_byte   = 1'b0;
        res[k].run_last   = 1'b1;
        res[k].string_end = 1'b1;
      end else begin
        res[k].byte_out   = bytes[k];
        res[k].has_byte   = 1'b1;
        res[k].run_last   = (2'(k) == nb - 2'd1);
        res[k].string_end = (2'(k) == nb - 2'd1) && in_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r    <= 18'd0;
      scnt_r    <= 2'd0;
      stopped_r <= 1'b0;
    end else if (in_acc) begin
      hold_r    <= hold_nxt;
      scnt_r    <= scnt_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < MaxRes; k++) begin
        if (2'(k) < n_res) begin
          fifo_mem[wr_ptr_r + PtrW'(k)] <= res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + (in_acc ? CntW'(n_res) : CntW'(0))
                    - (out_acc ? CntW'(1) : CntW'(0));
    end
  end

  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = {7'd0, fifo_mem[rd_ptr_r].run_last, fifo_mem[rd_ptr_r].byte_out};
  assign out_tuser  = fifo_mem[rd_ptr_r].has_byte;
  assign out_tlast  = fifo_mem[rd_ptr_r].string_end;

  `B64D_ASSERT_IMPL(a_fifo_bound, clk, rst_n, 1'b1, fifo_cnt_r <= CntW'(FifoDepth), "result queue overflow")
  `B64D_ASSERT_NEXT(a_string_clear, clk, rst_n, in_acc && in_tlast, scnt_r == 2'd0 && !stopped_r, "state not cleared after string end")
  `B64D_ASSERT_NEXT(a_stopped_quiet, clk, rst_n, stopped_r && in_acc && !in_tlast, fifo_cnt_r <= $past(fifo_cnt_r), "result produced after stop")

endmodule
